/* sv/fragment_ring_queue_commit_unit_assert.svh */
// Assertion macros shared by the fragment ring queue RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef FRAGMENT_RING_QUEUE_COMMIT_UNIT_ASSERT_SVH
`define FRAGMENT_RING_QUEUE_COMMIT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define FRQC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frqc assertion failed");

// Next-cycle implication, disabled while reset is low
`define FRQC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frqc assertion failed");

`endif

/* sv/frqc_pkg.sv */
// Package for the fragment ring queue: opcodes, result status codes,
// controller state type and fixed limits. No dependencies.
package frqc_pkg;

  // request opcodes
  localparam logic [1:0] OP_PUSH     = 2'd0;
  localparam logic [1:0] OP_BURST    = 2'd1;
  localparam logic [1:0] OP_COMPLETE = 2'd2;

  // result status codes
  typedef enum logic [3:0] {
    RS_HELD      = 4'd0,
    RS_COMMITTED = 4'd1,
    RS_DROPPED   = 4'd2,
    RS_INVALID   = 4'd3,
    RS_READ_BYTE = 4'd4,
    RS_EMPTY     = 4'd5,
    RS_REFUSED   = 4'd6,
    RS_COMPLETED = 4'd7,
    RS_IGNORED   = 4'd8
  } res_status_t;

  // controller states
  typedef enum logic {
    FSM_IDLE  = 1'b0,
    FSM_BURST = 1'b1
  } fsm_state_t;

  // fragment length limit cap and fragment byte counter saturation
  localparam logic [10:0] LIMIT_CAP = 11'd1024;
  localparam logic [10:0] COUNT_SAT = 11'd2047;

endpackage

/* sv/fragment_ring_queue_commit_unit.sv */
// Fragment ring queue with peek and commit: byte store, pointers, drop counters.
// Depends on frqc_pkg and fragment_ring_queue_commit_unit_assert.svh.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  in_     | input     | in_valid/in_stall | op, data_byte, last_of_fragment, ...
//  out_    | output    | out_valid/out_stall | status, read_byte, last_result, ...
//  cfg_    | input     | cfg_valid/cfg_ready | max_fragment_length (11 bit)
//
// Push, completion and refused/empty bursts each give one result.
// A burst of n bytes holds the input until its last byte reaches the output; the
// single read port of the byte store gives one byte per cycle unless output stalls.
// Synchronous active-low reset clears pointers, counters and flags; the byte
// store is not cleared. Output stall backs up into the burst reader and input.
`include "fragment_ring_queue_commit_unit_assert.svh"

module fragment_ring_queue_commit_unit
  import frqc_pkg::*;
#(
  parameter int STORAGE_DEPTH = 1024,
  parameter int BURST_MAX     = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // request input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_of_fragment,
  input  logic        in_fragment_error,
  input  logic [6:0]  in_burst_request,
  input  logic [6:0]  in_accepted_count,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [7:0]  out_read_byte,
  output logic        out_last_result,
  output logic [9:0]  out_queued_bytes,
  output logic [31:0] out_dropped_frames,
  output logic [31:0] out_dropped_bytes,
  output logic        out_retry_needed,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  localparam int AW = $clog2(STORAGE_DEPTH);
  localparam logic [AW-1:0]   LAST_IDX = AW'(STORAGE_DEPTH - 1);
  localparam logic [AW-1:0]   DEPTH_AW = AW'(STORAGE_DEPTH);
  localparam logic [AW+6:0]   DEPTH_WX = (AW+7)'(STORAGE_DEPTH);
  localparam logic [6:0]      BMAX     = 7'(BURST_MAX);

  // ring index helpers
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dist(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
    return (a >= b) ? (a - b) : (a - b + DEPTH_AW);
  endfunction

  // state registers
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] wc_r, wc_nxt;
  logic [10:0]   frag_cnt_r, frag_cnt_nxt;
  logic          frag_ovf_r, frag_ovf_nxt;
  logic          pend_r, pend_nxt;
  logic [6:0]    pend_len_r, pend_len_nxt;
  logic          retry_r, retry_nxt;
  logic [31:0]   drop_frames_r, drop_frames_nxt;
  logic [31:0]   drop_bytes_r, drop_bytes_nxt;
  logic [10:0]   max_len_r;

  fsm_state_t    state_r, state_nxt;

  // burst reader
  logic [AW-1:0] rd_idx_r;
  logic [6:0]    rd_left_r;
  logic          rd_pend_r, rd_pend_nxt;
  logic          rd_last_r;
  logic [7:0]    rd_data_r;
  logic          rd_en;
  logic          burst_out;

  // byte store
  logic [7:0]    mem [STORAGE_DEPTH];
  logic          mem_we;

  // output register
  logic          out_valid_r;
  logic [3:0]    out_status_r;
  logic [7:0]    out_read_byte_r;
  logic          out_last_r;
  logic [9:0]    out_queued_r;
  logic [31:0]   out_frames_r;
  logic [31:0]   out_bytes_r;
  logic          out_retry_r;

  logic          out_free;
  logic          in_acc;
  logic          item_out;
  logic          burst_go;
  res_status_t   res_status;

  // push datapath
  logic [AW-1:0] q_cur;
  logic [AW-1:0] free_space;
  logic [10:0]   push_cnt;
  logic [10:0]   limit;
  logic          push_room;
  logic          push_store;
  logic          push_ovf;
  logic          push_bad;
  logic [AW-1:0] push_wc;

  // burst sizing and completion datapath
  logic [6:0]    req_cap;
  logic [AW+6:0] q_ext;
  logic [6:0]    burst_n;
  logic [6:0]    acc_clamp;
  logic [AW+6:0] tail_sum;
  logic [AW+6:0] tail_wrap;
  logic [AW+9:0] q_nxt_ext;

  assign out_free = !out_valid_r || !out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // push: byte-wise space check, tentative write at the cursor
  assign q_cur      = wrap_dist(head_r, tail_r);
  assign free_space = LAST_IDX - q_cur;
  assign push_cnt   = (frag_cnt_r < COUNT_SAT) ? frag_cnt_r + 11'd1 : frag_cnt_r;
  assign push_room  = wrap_dist(wc_r, head_r) < free_space;
  assign push_store = !frag_ovf_r && push_room;
  assign push_ovf   = frag_ovf_r || !push_room;
  assign push_wc    = push_store ? ptr_inc(wc_r) : wc_r;
  assign limit      = (max_len_r > LIMIT_CAP) ? LIMIT_CAP : max_len_r;
  assign push_bad   = in_fragment_error || (push_cnt > limit);

  // burst size: min(request, BURST_MAX, queued)
  assign req_cap = (in_burst_request > BMAX) ? BMAX : in_burst_request;
  assign q_ext   = {7'b0, q_cur};
  assign burst_n = (q_ext < {{AW{1'b0}}, req_cap}) ? q_ext[6:0] : req_cap;

  // completion: clamp and advance tail with wrap
  assign acc_clamp = (in_accepted_count > pend_len_r) ? pend_len_r : in_accepted_count;
  assign tail_sum  = {7'b0, tail_r} + {{AW{1'b0}}, acc_clamp};
  assign tail_wrap = (tail_sum >= DEPTH_WX) ? tail_sum - DEPTH_WX : tail_sum;

  // request processing
  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    wc_nxt          = wc_r;
    frag_cnt_nxt    = frag_cnt_r;
    frag_ovf_nxt    = frag_ovf_r;
    pend_nxt        = pend_r;
    pend_len_nxt    = pend_len_r;
    retry_nxt       = retry_r;
    drop_frames_nxt = drop_frames_r;
    drop_bytes_nxt  = drop_bytes_r;
    mem_we          = 1'b0;
    burst_go        = 1'b0;
    res_status      = RS_IGNORED;
    if (in_acc) begin
      case (in_op)
        OP_PUSH: begin
          mem_we       = push_store;
          frag_cnt_nxt = push_cnt;
          frag_ovf_nxt = push_ovf;
          wc_nxt       = push_wc;
          if (!in_last_of_fragment) begin
            res_status = RS_HELD;
          end else begin
            frag_cnt_nxt = '0;
            frag_ovf_nxt = 1'b0;
            if (push_bad) begin
              res_status = RS_INVALID;
              wc_nxt     = head_r;
            end else if (push_ovf) begin
              res_status      = RS_DROPPED;
              drop_frames_nxt = drop_frames_r + 32'd1;
              drop_bytes_nxt  = drop_bytes_r + {21'b0, push_cnt};
              wc_nxt          = head_r;
            end else begin
              res_status = RS_COMMITTED;
              head_nxt   = push_wc;
            end
          end
        end
        OP_BURST: begin
          if (pend_r) begin
            res_status = RS_REFUSED;
          end else if (burst_n == 7'd0) begin
            res_status = RS_EMPTY;
          end else begin
            res_status   = RS_READ_BYTE;
            burst_go     = 1'b1;
            pend_nxt     = 1'b1;
            pend_len_nxt = burst_n;
          end
        end
        OP_COMPLETE: begin
          if (!pend_r) begin
            res_status = RS_IGNORED;
          end else begin
            res_status = RS_COMPLETED;
            if (in_accepted_count == 7'd0) begin
              retry_nxt = 1'b1;
            end else begin
              tail_nxt  = tail_wrap[AW-1:0];
              retry_nxt = 1'b0;
            end
            pend_nxt     = 1'b0;
            pend_len_nxt = '0;
          end
        end
        default: begin
          res_status = RS_IGNORED;
        end
      endcase
    end
  end

  assign item_out  = in_acc && !burst_go;
  assign q_nxt_ext = {10'b0, wrap_dist(head_nxt, tail_nxt)};

  // controller next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (burst_go) state_nxt = FSM_BURST;
      end
      FSM_BURST: begin
        if (burst_out && rd_last_r) state_nxt = FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_stall    = 1'b1;
    rd_en       = 1'b0;
    burst_out   = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        in_stall = !out_free;
      end
      FSM_BURST: begin
        burst_out = rd_pend_r && out_free;
        rd_en     = (rd_left_r != 7'd0) && (!rd_pend_r || out_free);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // a read in flight stays until its byte moves to the output register
  always_comb begin
    rd_pend_nxt = rd_pend_r;
    if (rd_en) rd_pend_nxt = 1'b1;
    else if (burst_out) rd_pend_nxt = 1'b0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= FSM_IDLE;
      head_r        <= '0;
      tail_r        <= '0;
      wc_r          <= '0;
      frag_cnt_r    <= '0;
      frag_ovf_r    <= 1'b0;
      pend_r        <= 1'b0;
      pend_len_r    <= '0;
      retry_r       <= 1'b0;
      drop_frames_r <= '0;
      drop_bytes_r  <= '0;
      max_len_r     <= LIMIT_CAP;
      rd_pend_r     <= 1'b0;
      rd_left_r     <= '0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      wc_r          <= wc_nxt;
      frag_cnt_r    <= frag_cnt_nxt;
      frag_ovf_r    <= frag_ovf_nxt;
      pend_r        <= pend_nxt;
      pend_len_r    <= pend_len_nxt;
      retry_r       <= retry_nxt;
      drop_frames_r <= drop_frames_nxt;
      drop_bytes_r  <= drop_bytes_nxt;
      rd_pend_r     <= rd_pend_nxt;
      if (cfg_valid && cfg_ready) max_len_r <= cfg_data;
      if (burst_go) rd_left_r <= burst_n;
      else if (rd_en) rd_left_r <= rd_left_r - 7'd1;
    end
  end

  // burst read address and last marker
  always_ff @(posedge clk) begin
    if (burst_go) begin
      rd_idx_r <= tail_r;
    end else if (rd_en) begin
      rd_idx_r  <= ptr_inc(rd_idx_r);
      rd_last_r <= (rd_left_r == 7'd1);
    end
  end

  // byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[wc_r] <= in_data_byte;
    if (rd_en) rd_data_r <= mem[rd_idx_r];
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_out || burst_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload; head and tail hold still during a burst
  always_ff @(posedge clk) begin
    if (item_out) begin
      out_status_r    <= res_status;
      out_read_byte_r <= 8'd0;
      out_last_r      <= 1'b1;
      out_queued_r    <= q_nxt_ext[9:0];
      out_frames_r    <= drop_frames_nxt;
      out_bytes_r     <= drop_bytes_nxt;
      out_retry_r     <= retry_nxt;
    end else if (burst_out) begin
      out_status_r    <= RS_READ_BYTE;
      out_read_byte_r <= rd_data_r;
      out_last_r      <= rd_last_r;
      out_queued_r    <= q_nxt_ext[9:0];
      out_frames_r    <= drop_frames_r;
      out_bytes_r     <= drop_bytes_r;
      out_retry_r     <= retry_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_byte      = out_read_byte_r;
  assign out_last_result    = out_last_r;
  assign out_queued_bytes   = out_queued_r;
  assign out_dropped_frames = out_frames_r;
  assign out_dropped_bytes  = out_bytes_r;
  assign out_retry_needed   = out_retry_r;

  // checks
  `FRQC_ASSERT_IMP(a_cursor_at_head, clk, rst_n, frag_cnt_r == 11'd0, wc_r == head_r)
  `FRQC_ASSERT_IMP(a_burst_pending, clk, rst_n, state_r == FSM_BURST, pend_r)
  `FRQC_ASSERT_IMP(a_pend_len, clk, rst_n, pend_r,
                   (pend_len_r != 7'd0) && (pend_len_r <= BMAX))
  `FRQC_ASSERT_IMP(a_read_in_burst, clk, rst_n, rd_pend_r, state_r == FSM_BURST)
  `FRQC_ASSERT_NXT(a_burst_start, clk, rst_n, burst_go, rd_left_r == pend_len_r)

endmodule
